FILE: sv/dpie_pkg.sv
`timescale 1ns / 1ps

package dpie_pkg;

   // item kinds
   typedef enum logic [1:0] {
      KIND_EXEC  = 2'd0,
      KIND_LOAD  = 2'd1,
      KIND_READ  = 2'd2,
      KIND_FLAGS = 2'd3
   } dpie_kind_type;

   // data-processing opcodes
   typedef enum logic [3:0] {
      OP_AND = 4'h0,
      OP_EOR = 4'h1,
      OP_SUB = 4'h2,
      OP_RSB = 4'h3,
      OP_ADD = 4'h4,
      OP_ADC = 4'h5,
      OP_SBC = 4'h6,
      OP_RSC = 4'h7,
      OP_TST = 4'h8,
      OP_TEQ = 4'h9,
      OP_CMP = 4'ha,
      OP_CMN = 4'hb,
      OP_ORR = 4'hc,
      OP_MOV = 4'hd,
      OP_BIC = 4'he,
      OP_MVN = 4'hf
   } dpie_op_type;

   // instruction format fields
   localparam logic [31:0] COND_MASK    = 32'he0000000;
   localparam logic [31:0] SBZ_MASK     = 32'h00000f00;
   localparam logic [31:0] REG_SBZ_MASK = 32'h000000f0;
   localparam int          IMM_BIT      = 25;
   localparam int          SET_BIT      = 20;

   // flag bit positions within nzcv
   localparam int FLAG_N_BIT = 3;
   localparam int FLAG_Z_BIT = 2;
   localparam int FLAG_C_BIT = 1;
   localparam int FLAG_V_BIT = 0;

   typedef struct packed {
      logic [1:0]  kind;
      logic [31:0] instruction;
      logic [3:0]  reg_index;
      logic [31:0] load_value;
   } dpie_req_type;

   typedef struct packed {
      logic        illegal;
      logic [31:0] result;
      logic [3:0]  dest_index;
      logic        wrote_back;
      logic [3:0]  flags;
   } dpie_rsp_type;

   // decoded operation handed from front to back
   typedef struct packed {
      dpie_kind_type kind;
      logic          illegal;
      dpie_op_type   opcode;
      logic          set_flags;
      logic          use_imm;
      logic [7:0]    imm8;
      logic [3:0]    addr_a;
      logic [3:0]    addr_b;
      logic [3:0]    dest;
      logic [31:0]   load_value;
   } dpie_uop_type;

endpackage

FILE: sv/dpie_fifo.sv
`timescale 1ns / 1ps

module dpie_fifo #(
   parameter type item_type = logic,
   parameter int  DEPTH     = 2
) (
   input  logic     clock,
   input  logic     reset,
   input  logic     push,
   input  item_type push_item,
   output logic     full,
   input  logic     pop,
   output item_type pop_item,
   output logic     empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   item_type           store_ff [DEPTH];
   logic [PTR_W-1:0]   head_ff, head_in;
   logic [PTR_W-1:0]   tail_ff, tail_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               do_push, do_pop;

   assign full     = (count_ff == CNT_W'(DEPTH));
   assign empty    = (count_ff == '0);
   assign pop_item = store_ff[head_ff];
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;

   // pointer and count update with wrap
   always_comb begin
      head_in  = head_ff;
      tail_in  = tail_ff;
      count_in = count_ff;
      if (do_push) begin
         tail_in = (tail_ff == PTR_W'(DEPTH - 1)) ? '0 : tail_ff + 1'b1;
      end
      if (do_pop) begin
         head_in = (head_ff == PTR_W'(DEPTH - 1)) ? '0 : head_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
      end
   end

   // storage write
   always_ff @(posedge clock) begin
      if (do_push) begin
         store_ff[tail_ff] <= push_item;
      end
   end

endmodule

FILE: sv/dpie_decode.sv
`timescale 1ns / 1ps

module dpie_decode (
   input  dpie_pkg::dpie_req_type req,
   output dpie_pkg::dpie_uop_type uop
);

   import dpie_pkg::*;

   logic [31:0] ir;
   logic        bad_fmt;

   assign ir = req.instruction;

   // format check on the instruction word
   assign bad_fmt = ((ir & COND_MASK) != COND_MASK) || ((ir & SBZ_MASK) != '0) ||
                    (!ir[IMM_BIT] && ((ir & REG_SBZ_MASK) != '0));

   // classify the transaction and pick register addresses
   always_comb begin
      uop.kind       = dpie_kind_type'(req.kind);
      uop.illegal    = bad_fmt;
      uop.opcode     = dpie_op_type'(ir[24:21]);
      uop.set_flags  = ir[SET_BIT];
      uop.use_imm    = ir[IMM_BIT];
      uop.imm8       = ir[7:0];
      uop.addr_a     = ir[19:16];
      uop.addr_b     = ir[3:0];
      uop.dest       = ir[15:12];
      uop.load_value = req.load_value;
      unique case (dpie_kind_type'(req.kind))
         KIND_EXEC: begin
         end
         KIND_LOAD: begin
            uop.dest = req.reg_index;
         end
         KIND_READ: begin
            uop.addr_a = req.reg_index;
            uop.dest   = req.reg_index;
         end
         KIND_FLAGS: begin
            uop.dest = '0;
         end
         default: begin
         end
      endcase
   end

endmodule

FILE: sv/dpie_exec.sv
`timescale 1ns / 1ps

module dpie_exec (
   input  logic                   clock,
   input  logic                   reset,
   input  dpie_pkg::dpie_uop_type in_item,
   input  logic                   in_empty,
   output logic                   in_pop,
   output dpie_pkg::dpie_rsp_type out_item,
   input  logic                   out_full,
   output logic                   out_push
);

   import dpie_pkg::*;

   localparam int NUM_REGS = 16;

   logic [31:0]         regfile_ff [NUM_REGS];
   logic [NUM_REGS-1:0] valid_ff, valid_in;
   logic                busy_ff, busy_in;
   dpie_uop_type        uop_ff;
   logic [31:0]         a_ff, b_ff;
   logic [3:0]          nzcv_ff, nzcv_in;
   logic                mark_ff, mark_in;

   logic        fire;
   logic        wr_en;
   logic [3:0]  wr_addr;
   logic [31:0] wr_data;
   logic [31:0] op_b, x, y, logic_res, alu_res;
   logic        cin, arith, carry, ovf, no_wb;
   logic [32:0] sum;

   // operand stage control
   assign fire     = busy_ff && !out_full;
   assign in_pop   = !in_empty && (!busy_ff || fire);
   assign out_push = fire;
   assign wr_en    = fire && out_item.wrote_back;
   assign wr_addr  = uop_ff.dest;
   assign wr_data  = out_item.result;

   always_comb begin
      busy_in = busy_ff;
      if (in_pop) begin
         busy_in = 1'b1;
      end else if (fire) begin
         busy_in = 1'b0;
      end
   end

   // register file with operand read, bypassing the write of the same edge
   always_ff @(posedge clock) begin
      if (wr_en) begin
         regfile_ff[wr_addr] <= wr_data;
      end
      if (in_pop) begin
         uop_ff <= in_item;
         if (wr_en && wr_addr == in_item.addr_a) begin
            a_ff <= wr_data;
         end else if (valid_ff[in_item.addr_a]) begin
            a_ff <= regfile_ff[in_item.addr_a];
         end else begin
            a_ff <= '0;
         end
         if (wr_en && wr_addr == in_item.addr_b) begin
            b_ff <= wr_data;
         end else if (valid_ff[in_item.addr_b]) begin
            b_ff <= regfile_ff[in_item.addr_b];
         end else begin
            b_ff <= '0;
         end
      end
   end

   // alu operand setup per opcode
   always_comb begin
      op_b      = uop_ff.use_imm ? {24'b0, uop_ff.imm8} : b_ff;
      x         = a_ff;
      y         = op_b;
      cin       = 1'b0;
      arith     = 1'b0;
      logic_res = '0;
      unique case (uop_ff.opcode)
         OP_AND, OP_TST: logic_res = a_ff & op_b;
         OP_EOR, OP_TEQ: logic_res = a_ff ^ op_b;
         OP_SUB, OP_CMP: begin
            y     = ~op_b;
            cin   = 1'b1;
            arith = 1'b1;
         end
         OP_RSB: begin
            x     = op_b;
            y     = ~a_ff;
            cin   = 1'b1;
            arith = 1'b1;
         end
         OP_ADD, OP_CMN: arith = 1'b1;
         OP_ADC: begin
            cin   = nzcv_ff[FLAG_C_BIT];
            arith = 1'b1;
         end
         OP_SBC: begin
            y     = ~op_b;
            cin   = nzcv_ff[FLAG_C_BIT];
            arith = 1'b1;
         end
         OP_RSC: begin
            x     = op_b;
            y     = ~a_ff;
            cin   = nzcv_ff[FLAG_C_BIT];
            arith = 1'b1;
         end
         OP_ORR: logic_res = a_ff | op_b;
         OP_MOV: logic_res = op_b;
         OP_BIC: logic_res = a_ff & ~op_b;
         OP_MVN: logic_res = ~op_b;
         default: logic_res = '0;
      endcase
      sum     = {1'b0, x} + {1'b0, y} + {32'b0, cin};
      alu_res = arith ? sum[31:0] : logic_res;
      carry   = arith & sum[32];
      ovf     = arith & (x[31] ^ sum[31]) & (y[31] ^ sum[31]);
      no_wb   = uop_ff.opcode inside {OP_TST, OP_TEQ, OP_CMP, OP_CMN};
   end

   // result and next architectural state per kind
   always_comb begin
      nzcv_in             = nzcv_ff;
      mark_in             = mark_ff;
      valid_in            = valid_ff;
      out_item.result     = '0;
      out_item.wrote_back = 1'b0;
      out_item.dest_index = uop_ff.dest;
      case (uop_ff.kind)
         KIND_EXEC: begin
            if (uop_ff.illegal) begin
               mark_in = 1'b1;
            end else begin
               mark_in             = 1'b0;
               out_item.result     = alu_res;
               out_item.wrote_back = !no_wb;
               if (uop_ff.set_flags) begin
                  nzcv_in = {alu_res[31], (alu_res == '0), carry, ovf};
               end
            end
         end
         KIND_LOAD: begin
            out_item.result     = uop_ff.load_value;
            out_item.wrote_back = 1'b1;
         end
         KIND_READ: begin
            out_item.result = a_ff;
         end
         KIND_FLAGS: begin
            nzcv_in = uop_ff.load_value[3:0];
         end
         default: begin
         end
      endcase
      if (fire && out_item.wrote_back) begin
         valid_in[wr_addr] = 1'b1;
      end
      out_item.illegal = mark_in;
      out_item.flags   = nzcv_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         valid_ff <= '0;
         nzcv_ff  <= '0;
         mark_ff  <= 1'b0;
      end else begin
         busy_ff  <= busy_in;
         valid_ff <= valid_in;
         if (fire) begin
            nzcv_ff <= nzcv_in;
            mark_ff <= mark_in;
         end
      end
   end

`ifndef SYNTH
   // an illegal instruction leaves the flags alone
   assert property (@(posedge clock) disable iff (reset)
      (fire && uop_ff.kind == KIND_EXEC && uop_ff.illegal) |=> (nzcv_ff == $past(nzcv_ff)))
      else $error("illegal instruction changed flags");

   // a retired operation with nothing behind it empties the stage
   assert property (@(posedge clock) disable iff (reset)
      (fire && !in_pop) |=> !busy_ff)
      else $error("operand stage kept a retired operation");

   // a written register reads back as valid
   assert property (@(posedge clock) disable iff (reset)
      wr_en |=> valid_ff[$past(wr_addr)])
      else $error("written register not marked valid");

   // a stalled operation keeps its operands
   assert property (@(posedge clock) disable iff (reset)
      (busy_ff && out_full) |=> ($stable(a_ff) && $stable(b_ff) && busy_ff))
      else $error("stalled operands changed");
`endif

endmodule

FILE: sv/data_processing_instruction_execute.sv
`timescale 1ns / 1ps

// Data-processing instruction executor with a 16 x 32-bit register file and NZCV flags.
// Request channel: push a transaction on req_item while req_full is low; it is either
// an instruction to execute, a register load, a register read or a flag write.
// Response channel: while rsp_empty is low rsp_item holds the oldest response; pop
// takes it. Every request yields exactly one response, in order.
// Flow: the decoder classifies each request into a short queue; the execute stage
// pops it, reads both operands from the register file into registers, and then,
// once the response queue has room, computes, writes back and pushes the response there.
// Throughput: one transaction per cycle unless the response queue is full, with a
// combinational alu and the one register-file write port; dependent instructions
// need no gap (write bypass).
// Reset: synchronous, clears the queues, the flags, the illegal mark and all
// register-file valid bits, so every register reads as zero afterwards.
// Stall: when rsp_pop stays low the response queue fills, the execute stage holds,
// then the request queue fills and req_full rises; nothing is lost.
module data_processing_instruction_execute #(
   parameter int QUEUE_DEPTH  = 2,
   parameter int RESULT_DEPTH = 2
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_push,
   input  dpie_pkg::dpie_req_type req_item,
   output logic                   req_full,
   input  logic                   rsp_pop,
   output dpie_pkg::dpie_rsp_type rsp_item,
   output logic                   rsp_empty
);

   import dpie_pkg::*;

   dpie_uop_type dec_uop;
   dpie_uop_type q_uop;
   logic         q_empty, q_pop;
   dpie_rsp_type ex_rsp;
   logic         ex_push, rq_full;

   // front: decode
   dpie_decode u_decode (
      .req (req_item),
      .uop (dec_uop)
   );

   // queue between front and back
   dpie_fifo #(
      .item_type (dpie_uop_type),
      .DEPTH     (QUEUE_DEPTH)
   ) u_uop_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (req_push),
      .push_item (dec_uop),
      .full      (req_full),
      .pop       (q_pop),
      .pop_item  (q_uop),
      .empty     (q_empty)
   );

   // back: operand read and execute
   dpie_exec u_exec (
      .clock    (clock),
      .reset    (reset),
      .in_item  (q_uop),
      .in_empty (q_empty),
      .in_pop   (q_pop),
      .out_item (ex_rsp),
      .out_full (rq_full),
      .out_push (ex_push)
   );

   // response queue
   dpie_fifo #(
      .item_type (dpie_rsp_type),
      .DEPTH     (RESULT_DEPTH)
   ) u_rsp_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (ex_push),
      .push_item (ex_rsp),
      .full      (rq_full),
      .pop       (rsp_pop),
      .pop_item  (rsp_item),
      .empty     (rsp_empty)
   );

endmodule
